@@ hdl/tbwc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbwc_pkg: shared types for the time bucket window counter
// Item and result structs, field widths and the count ceiling.
// ----------------------------------------------------------------------------
package tbwc_pkg;

	localparam int BUCKET_W = 32;
	localparam int COUNT_W  = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef struct packed {
		logic [BUCKET_W-1:0] current_bucket;
		logic [COUNT_W-1:0]  detections;
	} tbwc_in_t;

	typedef struct packed {
		logic [COUNT_W-1:0] window_total;
		logic               expired_any;
	} tbwc_out_t;

endpackage

@@ hdl/time_bucket_window_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_bucket_window_counter: sliding window bucketed event counter
// Keeps SLOTS bucket slots, expires stale ones, adds detections, reports total.
// ----------------------------------------------------------------------------
// An item is accepted when start is high and busy is low. The block then
// walks the slot RAM one slot per cycle: expiry, hit search, first empty slot,
// oldest slot and the running total are all gathered in that single pass,
// after which the FIN state writes the updated slot when detections are
// nonzero. done is registered in FIN and stays high for exactly one cycle;
// the result is taken at the edge that ends it, and the receiver cannot stall
// it. A new item may be accepted at that same edge, but not while busy, so
// the block takes no new item until the current one is through: the slot
// pass, the slot RAM read and the FIN write all lie between two items.
module time_bucket_window_counter #(
	parameter int SLOTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tbwc_pkg::tbwc_in_t request,
	output logic               done,
	output tbwc_pkg::tbwc_out_t result
);
	import tbwc_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int SW = COUNT_W + IW + 1;
	localparam int EW = BUCKET_W + COUNT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [IW-1:0]       LAST_IDX = IW'(SLOTS - 1);
	localparam logic [BUCKET_W-1:0] SPAN     = BUCKET_W'(SLOTS - 1);

	logic [1:0]          state_q;
	logic [BUCKET_W-1:0] now_q, lo_q;
	logic [COUNT_W-1:0]  det_q;
	logic [SLOTS-1:0]    valid_q;
	logic [IW-1:0]       rd_idx_q;
	logic                issued_q;
	logic                rv_s1;
	logic [IW-1:0]       ix_s1;

	logic                exp_any_q;
	logic [SW-1:0]       sum_q;
	logic                hit_q, empty_q, old_q;
	logic [IW-1:0]       hit_idx_q, empty_idx_q, old_idx_q;
	logic [COUNT_W-1:0]  hit_cnt_q, old_cnt_q;
	logic [BUCKET_W-1:0] old_b_q;

	logic                rd_en;
	logic [EW-1:0]       rd_data;
	logic [BUCKET_W-1:0] rd_b;
	logic [COUNT_W-1:0]  rd_c;
	logic                cur_vld, cur_exp;

	logic                wr_en;
	logic [IW-1:0]       tgt_idx;
	logic [COUNT_W-1:0]  base_cnt, sub_cnt, new_cnt;
	logic [COUNT_W:0]    add_cnt;
	logic [SW-1:0]       tot_raw;
	logic [COUNT_W-1:0]  tot_sat;

	assign busy  = (state_q != ST_IDLE);
	assign rd_en = (state_q == ST_SCAN) && !issued_q;

	assign rd_b    = rd_data[EW-1:COUNT_W];
	assign rd_c    = rd_data[COUNT_W-1:0];
	assign cur_vld = valid_q[ix_s1];
	assign cur_exp = cur_vld && ((rd_b < lo_q) || (rd_b > now_q));

	always_comb begin
		priority if (hit_q) begin
			tgt_idx  = hit_idx_q;
			base_cnt = hit_cnt_q;
			sub_cnt  = hit_cnt_q;
		end else if (empty_q) begin
			tgt_idx  = empty_idx_q;
			base_cnt = '0;
			sub_cnt  = '0;
		end else begin
			tgt_idx  = old_idx_q;
			base_cnt = '0;
			sub_cnt  = old_cnt_q;
		end
		add_cnt = {1'b0, base_cnt} + {1'b0, det_q};
		new_cnt = add_cnt[COUNT_W] ? COUNT_MAX : add_cnt[COUNT_W-1:0];
		wr_en   = (state_q == ST_FIN) && (det_q != '0);
		if (det_q != '0) begin
			tot_raw = sum_q - SW'(sub_cnt) + SW'(new_cnt);
		end else begin
			tot_raw = sum_q;
		end
		tot_sat = (tot_raw > SW'(COUNT_MAX)) ? COUNT_MAX : tot_raw[COUNT_W-1:0];
	end

	tbwc_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tgt_idx),
		.wr_data ({now_q, new_cnt}),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			rd_idx_q  <= '0;
			issued_q  <= 1'b0;
			rv_s1     <= 1'b0;
			done      <= 1'b0;
			exp_any_q <= 1'b0;
			hit_q     <= 1'b0;
			empty_q   <= 1'b0;
			old_q     <= 1'b0;
		end else begin
			done  <= 1'b0;
			rv_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_SCAN;
						rd_idx_q  <= '0;
						issued_q  <= 1'b0;
						exp_any_q <= 1'b0;
						hit_q     <= 1'b0;
						empty_q   <= 1'b0;
						old_q     <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						if (rd_idx_q == LAST_IDX) begin
							issued_q <= 1'b1;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (rv_s1) begin
						if (cur_exp) begin
							valid_q[ix_s1] <= 1'b0;
							exp_any_q      <= 1'b1;
						end
						if (cur_vld && !cur_exp) begin
							if (!hit_q && (rd_b == now_q)) begin
								hit_q <= 1'b1;
							end
							if (!old_q || (rd_b < old_b_q)) begin
								old_q <= 1'b1;
							end
						end else if (!empty_q) begin
							empty_q <= 1'b1;
						end
						if (ix_s1 == LAST_IDX) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (det_q != '0) begin
						valid_q[tgt_idx] <= 1'b1;
					end
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		ix_s1 <= rd_idx_q;
		if (state_q == ST_IDLE && start) begin
			now_q <= request.current_bucket;
			det_q <= request.detections;
			lo_q  <= (request.current_bucket >= SPAN) ? request.current_bucket - SPAN : '0;
			sum_q <= '0;
		end
		if (state_q == ST_SCAN && rv_s1 && cur_vld && !cur_exp) begin
			sum_q <= sum_q + SW'(rd_c);
			if (!hit_q && (rd_b == now_q)) begin
				hit_idx_q <= ix_s1;
				hit_cnt_q <= rd_c;
			end
			if (!old_q || (rd_b < old_b_q)) begin
				old_idx_q <= ix_s1;
				old_cnt_q <= rd_c;
				old_b_q   <= rd_b;
			end
		end
		if (state_q == ST_SCAN && rv_s1 && !(cur_vld && !cur_exp) && !empty_q) begin
			empty_idx_q <= ix_s1;
		end
		if (state_q == ST_FIN) begin
			result.window_total <= tot_sat;
			result.expired_any  <= exp_any_q;
		end
	end

endmodule

@@ hdl/tbwc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbwc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tbwc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hdl/tbwc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbwc_checker: port-level checks for the time bucket window counter
// Handshake timing and result sanity, bound to the top level.
// ----------------------------------------------------------------------------
module tbwc_checker #(
	parameter int SLOTS = 8
) (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input tbwc_pkg::tbwc_in_t  request,
	input logic                done,
	input tbwc_pkg::tbwc_out_t result
);
	import tbwc_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted item");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(SLOTS+3) done)
		else $error("result strobe missing at expected latency");

	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_nonzero_total: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.detections != '0)) |->
			##(SLOTS+3) (result.window_total != '0))
		else $error("zero total after nonzero detections");

endmodule

bind time_bucket_window_counter tbwc_checker #(.SLOTS(SLOTS)) u_tbwc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);
